>>> design/nks_pkg.sv
// Shared types, codes and constants of the key unit scanner.
`timescale 1ns / 1ps
`default_nettype none

package nks_pkg;

    typedef enum logic [1:0] {
        CODEC_H264  = 2'd0,
        CODEC_HEVC  = 2'd1,
        CODEC_AVS2  = 2'd2,
        CODEC_OTHER = 2'd3
    } codec_t;

    localparam logic [7:0] AVS2_MARK_B0 = 8'hB0;
    localparam logic [7:0] AVS2_MARK_B3 = 8'hB3;
    localparam logic [7:0] AVS2_MARK_B6 = 8'hB6;

    localparam logic [5:0] AVS2_CODE_B0 = 6'd1;
    localparam logic [5:0] AVS2_CODE_B3 = 6'd2;
    localparam logic [5:0] AVS2_CODE_B6 = 6'd0;

    localparam logic [7:0] H264_TYPE_MASK = 8'h1F;
    localparam logic [7:0] HEVC_TYPE_MASK = 8'h7E;
    localparam logic [5:0] H264_TYPE_IDR  = 6'd5;
    localparam logic [5:0] H264_TYPE_SPS  = 6'd7;
    localparam logic [5:0] HEVC_TYPE_LO   = 6'd16;
    localparam logic [5:0] HEVC_TYPE_HI   = 6'h15;
    localparam logic [5:0] HEVC_TYPE_VPS  = 6'h20;

    localparam logic [2:0] COUNT_MAX = 3'd5;

    // Result of judging one byte.
    typedef struct packed {
        logic       emit;
        logic       found;
        logic [5:0] key_code;
    } match_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] code;
    } marker_t;

    function automatic marker_t avs2_marker(input logic [7:0] b);
        marker_t m;
        m.hit  = 1'b1;
        m.code = AVS2_CODE_B6;
        case (b)
            AVS2_MARK_B0: m.code = AVS2_CODE_B0;
            AVS2_MARK_B3: m.code = AVS2_CODE_B3;
            AVS2_MARK_B6: m.code = AVS2_CODE_B6;
            default:      m.hit  = 1'b0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> design/nks_if.sv
// Channel interfaces: byte words in, result words out, configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface nks_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       last_byte;

    modport source (output valid, output stream_byte, output last_byte, input ready);
    modport sink (input valid, input stream_byte, input last_byte, output ready);
endinterface

interface nks_result_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [5:0] key_code;

    modport source (output valid, output found, output key_code, input ready);
    modport sink (input valid, input found, input key_code, output ready);
endinterface

interface nks_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] codec_mode;

    modport source (output valid, output codec_mode, input ready);
    modport sink (input valid, input codec_mode, output ready);
endinterface

`default_nettype wire

>>> design/nks_match.sv
// Start code and key unit match for one byte against the scan window.
`timescale 1ns / 1ps
`default_nettype none

module nks_match
    import nks_pkg::*;
(
    input  wire codec_t      mode,
    input  wire logic [31:0] window,
    input  wire logic [2:0]  count,
    input  wire logic        done,
    input  wire logic [7:0]  cur_byte,
    input  wire logic        last,
    output match_t           res
);

    logic       sc3;
    logic       four;
    logic [5:0] h264_type;
    logic [5:0] hevc_type;
    marker_t    m_win;
    marker_t    m_cur;
    logic       hit;
    logic [5:0] code;

    assign sc3       = (count >= 3'd3) && (window[23:0] == 24'd1);
    assign four      = (count >= 3'd4) && (window[31:24] == 8'd0);
    assign h264_type = 6'(cur_byte & H264_TYPE_MASK);
    assign hevc_type = 6'((cur_byte & HEVC_TYPE_MASK) >> 1);
    // Short form marker sits in the third byte, long form in the fourth.
    assign m_win     = avs2_marker((window[15:8] == 8'd1) ? window[7:0] : window[15:8]);
    assign m_cur     = avs2_marker(cur_byte);

    always_comb
    begin
        hit  = 1'b0;
        code = 6'd0;
        if (!done)
        begin
            case (mode)
                CODEC_H264:
                begin
                    if (sc3 && (!last || four) &&
                        ((h264_type == H264_TYPE_IDR) || (h264_type == H264_TYPE_SPS)))
                    begin
                        hit  = 1'b1;
                        code = h264_type;
                    end
                end
                CODEC_HEVC:
                begin
                    if (sc3 && (!last || four) &&
                        (((hevc_type >= HEVC_TYPE_LO) && (hevc_type <= HEVC_TYPE_HI)) ||
                         (hevc_type == HEVC_TYPE_VPS)))
                    begin
                        hit  = 1'b1;
                        code = hevc_type;
                    end
                end
                CODEC_AVS2:
                begin
                    // Marker at packet start, confirmed on the fifth byte.
                    if ((count == 3'd4) && (window[31:16] == 16'd0) && m_win.hit)
                    begin
                        hit  = 1'b1;
                        code = m_win.code;
                    end
                    else if ((count >= 3'd4) && (window[23:0] == 24'd1) && m_cur.hit)
                    begin
                        hit  = 1'b1;
                        code = m_cur.code;
                    end
                    else if ((count >= 3'd3) && !last && (window[15:0] == 16'd0) &&
                             m_cur.hit)
                    begin
                        hit  = 1'b1;
                        code = m_cur.code;
                    end
                end
                default:
                begin
                    hit  = 1'b0;
                    code = 6'd0;
                end
            endcase
        end
    end

    assign res.emit     = hit || (last && !done);
    assign res.found    = hit;
    assign res.key_code = hit ? code : 6'd0;

endmodule

`default_nettype wire

>>> design/nal_key_unit_scanner.sv
// Top level of the Annex B key unit scanner.
//
//   channel    modport  word                        handshake
//   byte_in    sink     stream_byte[7:0], last_byte valid/ready
//   result     source   found, key_code[5:0]        valid/ready
//   cfg        sink     codec_mode[1:0]             valid/ready (ready tied high)
//
// One byte word per cycle sustained while no result word is stalled.
// A byte is captured in the input register, judged against the scan window
// from there, and any result lands in the output register.
// Every packet yields exactly one result word (first key unit or not-found).
// Reset clears the scan window, byte count, done flag and codec_mode (H.264).
// A stalled result holds the judged byte; byte_in still takes words while
// the input stage judges bytes that produce no result.
`timescale 1ns / 1ps
`default_nettype none

module nal_key_unit_scanner
    import nks_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    nks_byte_if.sink      byte_in,
    nks_result_if.source  result,
    nks_cfg_if.sink       cfg
);

    // Input stage.
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;

    // Scan state.
    codec_t      mode_reg;
    logic [31:0] window_reg;
    logic [31:0] window_next;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic        done_reg;
    logic        done_next;

    // Output register.
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_found_reg;
    logic [5:0]  out_code_reg;

    match_t      res;
    logic        advance;
    logic        in_take;

    nks_match u_match (
        .mode     (mode_reg),
        .window   (window_reg),
        .count    (count_reg),
        .done     (done_reg),
        .cur_byte (s1_byte_reg),
        .last     (s1_last_reg),
        .res      (res)
    );

    // Advance the input stage unless its result would overwrite one still waiting.
    assign advance = s1_valid_reg && (!res.emit || !out_valid_reg || result.ready);
    assign byte_in.ready = !s1_valid_reg || advance;
    assign in_take = byte_in.valid && byte_in.ready;
    assign cfg.ready = 1'b1;

    assign result.valid    = out_valid_reg;
    assign result.found    = out_found_reg;
    assign result.key_code = out_code_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        window_next = window_reg;
        count_next  = count_reg;
        done_next   = done_reg;
        if (advance)
        begin
            if (s1_last_reg)
            begin
                // Drop all packet state at the packet's end.
                window_next = 32'd0;
                count_next  = 3'd0;
                done_next   = 1'b0;
            end
            else
            begin
                window_next = {window_reg[23:0], s1_byte_reg};
                count_next  = (count_reg < COUNT_MAX) ? count_reg + 3'd1 : COUNT_MAX;
                done_next   = done_reg || res.found;
            end
        end

        out_valid_next = out_valid_reg;
        if (advance && res.emit)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            mode_reg      <= CODEC_H264;
            window_reg    <= 32'd0;
            count_reg     <= 3'd0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            window_reg    <= window_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
                mode_reg <= codec_t'(cfg.codec_mode);
        end
    end

    // Payload registers: load only, no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= byte_in.stream_byte;
            s1_last_reg <= byte_in.last_byte;
        end
        if (advance && res.emit)
        begin
            out_found_reg <= res.found;
            out_code_reg  <= res.key_code;
        end
    end

endmodule

`default_nettype wire

>>> design/nks_checker.sv
// Port-level assertions for the key unit scanner and their bind.
`timescale 1ns / 1ps
`default_nettype none

module nks_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       out_found,
    input wire logic [5:0] out_key_code
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_key_code))
        else $error("result word changed while stalled");

    // A not-found word carries code zero.
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_found |-> out_key_code == 6'd0)
        else $error("not-found result with nonzero key_code");

    // A found word carries a code of some key unit.
    a_found_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_found |->
            (out_key_code <= 6'd2) || (out_key_code == 6'd5) || (out_key_code == 6'd7) ||
            ((out_key_code >= 6'd16) && (out_key_code <= 6'd21)) ||
            (out_key_code == 6'd32))
        else $error("found result with illegal key_code");

    // With the output register empty the scanner never stalls its input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

endmodule

bind nal_key_unit_scanner nks_checker u_nks_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (byte_in.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_found    (result.found),
    .out_key_code (result.key_code)
);

`default_nettype wire

>>> test/tb_nal_key_unit_scanner.sv
// Testbench of the key unit scanner: directed packets from a table, then random packet phases.
`timescale 1ns / 1ps

module tb_nal_key_unit_scanner;
    import nks_pkg::*;

    localparam int unsigned HALF_PERIOD     = 2;
    localparam int unsigned RESET_CYCLES    = 3;
    // Leave margin for bytes still in the pipeline before touching the register.
    localparam int unsigned DRAIN_CYCLES    = 4;
    localparam int unsigned STALL_LIMIT     = 3000;
    localparam int unsigned RANDOM_BYTES    = 750;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned PHASE_PACKETS   = 12;

    // Key unit types and markers as the scanner must recognize them.
    localparam logic [4:0] H264_IDR       = 5'd5;
    localparam logic [4:0] H264_SPS       = 5'd7;
    localparam logic [5:0] HEVC_KEY_FIRST = 6'd16;
    localparam logic [5:0] HEVC_KEY_LAST  = 6'd21;
    localparam logic [5:0] HEVC_VPS       = 6'd32;
    localparam logic [7:0] MARK_B0        = 8'hB0;
    localparam logic [7:0] MARK_B3        = 8'hB3;
    localparam logic [7:0] MARK_B6        = 8'hB6;
    localparam logic [5:0] AVS2_KEY_B0    = 6'd1;
    localparam logic [5:0] AVS2_KEY_B3    = 6'd2;
    localparam logic [5:0] AVS2_KEY_B6    = 6'd0;

    typedef struct packed {
        logic       found;
        logic [5:0] key_code;
    } key_word_t;

    typedef enum logic {
        ROW_BYTE,
        ROW_MODE
    } row_kind_t;

    // One step of the directed table: either a byte word or a codec change.
    typedef struct packed {
        row_kind_t  kind;
        codec_t     mode;
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic       found;
        logic [5:0] key_code;
    } dir_row_t;

    localparam int DIR_ROWS = 35;

    logic clk = 1'b0;
    logic rst_n;

    nks_byte_if   byte_in ();
    nks_result_if result ();
    nks_cfg_if    cfg ();

    nal_key_unit_scanner u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .result  (result),
        .cfg     (cfg)
    );

    always #HALF_PERIOD clk = ~clk;

    // Scanner state as predicted, at reset values.
    logic [31:0] scan_window = '0;
    logic [2:0]  bytes_seen  = '0;
    logic        pkt_done    = 1'b0;
    codec_t      cur_mode    = CODEC_H264;

    // Result words still owed by the block, oldest first.
    key_word_t   key_q[$];
    key_word_t   head_word;

    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;
    int unsigned hold_left   = 0;
    int unsigned idle_cycles = 0;
    int unsigned mismatches  = 0;
    int unsigned bytes_sent  = 0;
    int unsigned round_ix;

    dir_row_t dir_rows [DIR_ROWS];

    // Map an AVS2 marker to its key code; leave code untouched on a miss.
    function automatic logic avs2_lookup(input logic [7:0] b, inout logic [5:0] code);
        avs2_lookup = 1'b1;
        case (b)
            MARK_B0: code = AVS2_KEY_B0;
            MARK_B3: code = AVS2_KEY_B3;
            MARK_B6: code = AVS2_KEY_B6;
            default: avs2_lookup = 1'b0;
        endcase
    endfunction

    // Judge one accepted byte, advance the scan state, and return 1 when the
    // byte causes a result word (placed in w).
    function automatic logic scan_byte(input logic [7:0] b, input logic lst,
                                       output key_word_t w);
        logic       hit;
        logic       sc3;
        logic       four;
        logic [5:0] t;
        logic [7:0] mark;
        hit = 1'b0;
        t   = '0;
        if (!pkt_done)
        begin
            case (cur_mode)
                CODEC_H264, CODEC_HEVC:
                begin
                    sc3  = bytes_seen >= 3'd3 && scan_window[23:0] == 24'h000001;
                    four = bytes_seen >= 3'd4 && scan_window[31:24] == 8'h00;
                    // A three-byte start code right before the last byte does not count.
                    if (sc3 && (!lst || four))
                    begin
                        if (cur_mode == CODEC_H264)
                        begin
                            t   = {1'b0, b[4:0]};
                            hit = b[4:0] == H264_IDR || b[4:0] == H264_SPS;
                        end
                        else
                        begin
                            t   = b[6:1];
                            hit = (t >= HEVC_KEY_FIRST && t <= HEVC_KEY_LAST) || t == HEVC_VPS;
                        end
                    end
                end
                CODEC_AVS2:
                begin
                    // A marker that starts on the first byte is confirmed on the fifth.
                    if (bytes_seen == 3'd4 && scan_window[31:16] == 16'h0000)
                    begin
                        mark = scan_window[15:8] == 8'h01 ? scan_window[7:0] : scan_window[15:8];
                        hit  = avs2_lookup(mark, t);
                    end
                    if (!hit && bytes_seen >= 3'd4 && scan_window[23:0] == 24'h000001)
                        hit = avs2_lookup(b, t);
                    if (!hit && bytes_seen >= 3'd3 && !lst && scan_window[15:0] == 16'h0000)
                        hit = avs2_lookup(b, t);
                end
                default:
                    hit = 1'b0;
            endcase
        end

        scan_byte  = hit || (lst && !pkt_done);
        w.found    = hit;
        w.key_code = hit ? t : 6'd0;

        if (hit)
            pkt_done = 1'b1;
        scan_window = {scan_window[23:0], b};
        bytes_seen  = bytes_seen < 3'd5 ? bytes_seen + 3'd1 : 3'd5;
        if (lst)
        begin
            scan_window = '0;
            bytes_seen  = '0;
            pkt_done    = 1'b0;
        end
    endfunction

    // Zero-heavy filler so that start codes also form by chance.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(3))
            0:       noise_byte = 8'h00;
            1:       noise_byte = 8'h01;
            default: noise_byte = 8'($urandom);
        endcase
    endfunction

    // Offer one byte word, idling first as the phase asks; on acceptance
    // advance the predictor and queue the result it owes. A typed row
    // replaces the predicted word with the one given in the table.
    task automatic offer_byte(input logic [7:0] b, input logic lst, input logic typed,
                              input key_word_t typed_word);
        key_word_t w;
        logic      emit;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            byte_in.valid <= 1'b0;
            @(negedge clk);
        end
        byte_in.valid       <= 1'b1;
        byte_in.stream_byte <= b;
        byte_in.last_byte   <= lst;
        do
            @(posedge clk);
        while (!byte_in.ready);
        emit = scan_byte(b, lst, w);
        if (typed)
        begin
            emit = 1'b1;
            w    = typed_word;
        end
        if (emit)
            key_q.push_back(w);
        bytes_sent++;
    endtask

    // Drop valid, drain every owed result plus the pipeline, then write the codec.
    task automatic set_codec(input codec_t m);
        @(negedge clk);
        byte_in.valid <= 1'b0;
        while (key_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        cfg.valid      <= 1'b1;
        cfg.codec_mode <= m;
        do
            @(posedge clk);
        while (!cfg.ready);
        cur_mode = m;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // One random phase: fixed codec, idling and stalling, a run of packets. Most packets
    // carry one or two start codes with a key or random header; the rest are noise.
    task automatic run_phase(input codec_t m, input int unsigned idle, input int unsigned stall,
                             input logic hold, input int unsigned packets);
        logic [7:0]  pkt[$];
        logic [7:0]  hdr;
        int unsigned shape;
        set_codec(m);
        idle_pct  = idle;
        stall_pct = stall;
        if (hold)
        begin
            // Hold the result side off while bytes keep coming, so the block backs up.
            @(posedge clk);
            hold_left = HOLD_OFF_CYCLES;
        end
        repeat (packets)
        begin
            pkt.delete();
            shape = $urandom_range(9);
            repeat ($urandom_range(3))
                pkt.push_back(noise_byte());
            if (shape < 7)
            begin
                repeat (1 + $urandom_range(1))
                begin
                    if ($urandom_range(1) != 0)
                        pkt.push_back(8'h00);
                    pkt.push_back(8'h00);
                    pkt.push_back(8'h00);
                    // Skip the 01 now and then: AVS2 short form, or a broken code.
                    if ($urandom_range(3) != 0)
                        pkt.push_back(8'h01);
                    case ($urandom_range(5))
                        0: hdr = {3'($urandom), ($urandom_range(1) != 0) ? H264_IDR : H264_SPS};
                        1: hdr = {1'($urandom),
                                  6'($urandom_range(HEVC_KEY_FIRST, HEVC_KEY_LAST)),
                                  1'($urandom)};
                        2: hdr = {1'($urandom), HEVC_VPS, 1'($urandom)};
                        3:
                        begin
                            case ($urandom_range(2))
                                0:       hdr = MARK_B0;
                                1:       hdr = MARK_B3;
                                default: hdr = MARK_B6;
                            endcase
                        end
                        default: hdr = 8'($urandom);
                    endcase
                    pkt.push_back(hdr);
                end
            end
            repeat ($urandom_range(shape < 7 ? 3 : 10))
                pkt.push_back(noise_byte());
            if (pkt.size() == 0)
                pkt.push_back(noise_byte());
            foreach (pkt[i])
                offer_byte(pkt[i], i == pkt.size() - 1, 1'b0, '0);
        end
    endtask

    // Result side: stall at the phase rate, or hold off for a counted stretch.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            result.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            result.ready <= $urandom_range(99) >= stall_pct;
    end

    // Check each accepted result word against the oldest owed one, and end
    // the run when no channel moves a word for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                if (key_q.size() == 0)
                begin
                    $display("%0t: unexpected result word: found %0b key_code %0d",
                             $time, result.found, result.key_code);
                    mismatches++;
                end
                else
                begin
                    head_word = key_q.pop_front();
                    if (result.found !== head_word.found)
                    begin
                        $display("%0t: found mismatch: expected %0b, actual %0b",
                                 $time, head_word.found, result.found);
                        mismatches++;
                    end
                    if (result.key_code !== head_word.key_code)
                    begin
                        $display("%0t: key_code mismatch: expected %0d, actual %0d",
                                 $time, head_word.key_code, result.key_code);
                        mismatches++;
                    end
                end
            end
            if ((byte_in.valid && byte_in.ready) || (result.valid && result.ready) ||
                (cfg.valid && cfg.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        // Directed packets. Typed rows carry a result plain from the bytes;
        // untyped rows go through the predictor.
        dir_rows = '{
            // H.264 from reset: SPS after a three-byte code, tail ignored
            '{ROW_BYTE, CODEC_H264, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_H264, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_H264, 8'h01, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_H264, 8'h67, 1'b0, 1'b1, 1'b1, {1'b0, H264_SPS}},
            '{ROW_BYTE, CODEC_H264, 8'h00, 1'b1, 1'b0, 1'b0, 6'd0},
            // one-byte packet of all ones: not found
            '{ROW_BYTE, CODEC_H264, 8'hFF, 1'b1, 1'b1, 1'b0, 6'd0},
            // HEVC: VPS header on the last byte after a four-byte code
            '{ROW_MODE, CODEC_HEVC, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_HEVC, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_HEVC, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_HEVC, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_HEVC, 8'h01, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_HEVC, 8'h40, 1'b1, 1'b1, 1'b1, HEVC_VPS},
            // AVS2 short form at the packet head, confirmed on the fifth byte
            '{ROW_MODE, CODEC_AVS2, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_AVS2, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_AVS2, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_AVS2, 8'hB3, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_AVS2, 8'h12, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_AVS2, 8'h34, 1'b1, 1'b1, 1'b1, AVS2_KEY_B3},
            // other codec never finds anything
            '{ROW_MODE, CODEC_OTHER, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_OTHER, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_OTHER, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_OTHER, 8'h01, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_OTHER, 8'h65, 1'b1, 1'b1, 1'b0, 6'd0},
            // three-byte code with its IDR header as the last byte: no match
            '{ROW_MODE, CODEC_H264, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_H264, 8'h11, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_H264, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_H264, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_H264, 8'h01, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_H264, 8'h65, 1'b1, 1'b1, 1'b0, 6'd0},
            // codec switched mid-packet: the header is judged as HEVC
            '{ROW_BYTE, CODEC_H264, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_H264, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_H264, 8'h01, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_MODE, CODEC_HEVC, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_HEVC, 8'h26, 1'b0, 1'b0, 1'b0, 6'd0},
            '{ROW_BYTE, CODEC_HEVC, 8'h00, 1'b1, 1'b0, 1'b0, 6'd0}
        };

        // Drive every input to a known value before reset.
        rst_n               = 1'b0;
        byte_in.valid       = 1'b0;
        byte_in.stream_byte = '0;
        byte_in.last_byte   = 1'b0;
        result.ready        = 1'b0;
        cfg.valid           = 1'b0;
        cfg.codec_mode      = CODEC_H264;
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].kind == ROW_MODE)
                set_codec(dir_rows[r].mode);
            else
                offer_byte(dir_rows[r].data, dir_rows[r].last, dir_rows[r].typed,
                           {dir_rows[r].found, dir_rows[r].key_code});
        end

        // First round: each codec once, each idling pattern once.
        run_phase(CODEC_H264,  0,  0,  1'b0, PHASE_PACKETS);
        run_phase(CODEC_HEVC,  85, 0,  1'b0, PHASE_PACKETS);
        run_phase(CODEC_AVS2,  0,  85, 1'b0, PHASE_PACKETS);
        run_phase(CODEC_OTHER, 24, 24, 1'b0, PHASE_PACKETS);
        // Back-pressure: long hold-off on results while bytes stream in.
        run_phase(CODEC_H264,  0,  0,  1'b1, 2 * PHASE_PACKETS);

        // Further rounds with random codecs until enough bytes have gone in.
        round_ix = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            case (round_ix % 4)
                0: run_phase(codec_t'($urandom_range(3)), 0,  0,  1'b0, PHASE_PACKETS);
                1: run_phase(codec_t'($urandom_range(3)), 85, 0,  1'b0, PHASE_PACKETS);
                2: run_phase(codec_t'($urandom_range(3)), 0,  85, 1'b0, PHASE_PACKETS);
                default: run_phase(codec_t'($urandom_range(3)), 24, 24, 1'b0, PHASE_PACKETS);
            endcase
            round_ix++;
        end

        // Drain: drop valid, wait for every owed word, then watch for strays.
        @(negedge clk);
        byte_in.valid <= 1'b0;
        while (key_q.size() != 0)
            @(posedge clk);
        repeat (4 * DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
design/nks_pkg.sv
design/nks_if.sv
design/nks_match.sv
design/nal_key_unit_scanner.sv
design/nks_checker.sv
test/tb_nal_key_unit_scanner.sv
